@@ hdl/dht_pkg.sv @@
// Shared types and constants for the double-hashing table.
// Used by the channel interfaces, the remainder unit and the top level.
`default_nettype none

package dht_pkg;

  localparam int KEY_W    = 31;
  localparam int REC_W    = 16;
  localparam int SIZE_W   = 9;
  localparam int SLOT_W   = 8;
  localparam int STATUS_W = 2;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;
  localparam logic [SIZE_W-1:0] SIZE_MIN   = 9'd2;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_SEARCH = 1'b1;

  localparam logic [STATUS_W-1:0] ST_INSERTED  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FOUND     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic              used;
    logic [KEY_W-1:0]  key;
    logic [REC_W-1:0]  rec;
  } entry_t;

  typedef struct packed {
    logic              start;
    logic [KEY_W-1:0]  dividend;
    logic [SIZE_W-1:0] divisor;
  } mod_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [SIZE_W-1:0] rem;
  } mod_rsp_t;

endpackage

`default_nettype wire

@@ hdl/dht_req_if.sv @@
// Request channel: valid/ready handshake with kind, key and record id.
// Depends on dht_pkg for field widths.
`default_nettype none

interface dht_req_if;
  logic                       valid;
  logic                       ready;
  logic                       kind;
  logic [dht_pkg::KEY_W-1:0]  key;
  logic [dht_pkg::REC_W-1:0]  record_id;

  modport source (output valid, kind, key, record_id, input ready);
  modport sink   (input valid, kind, key, record_id, output ready);
endinterface

`default_nettype wire

@@ hdl/dht_rsp_if.sv @@
// Response channel: valid/ready handshake with status, record and slot.
// Depends on dht_pkg for field widths.
`default_nettype none

interface dht_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [dht_pkg::STATUS_W-1:0]  status;
  logic [dht_pkg::REC_W-1:0]     found_record;
  logic [dht_pkg::SLOT_W-1:0]    slot_index;

  modport source (output valid, status, found_record, slot_index, input ready);
  modport sink   (input valid, status, found_record, slot_index, output ready);
endinterface

`default_nettype wire

@@ hdl/dht_mod_unit.sv @@
// Bit-serial restoring remainder unit: key mod divisor, one key bit per cycle.
// Depends on dht_pkg for the request/response structs.
`default_nettype none

module dht_mod_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  dht_pkg::mod_req_t req,
  output dht_pkg::mod_rsp_t rsp
);

  localparam int CNT_W = $clog2(dht_pkg::KEY_W);

  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [CNT_W-1:0]              cnt_r;
  logic [dht_pkg::KEY_W-1:0]     dvd_r;
  logic [dht_pkg::SIZE_W-1:0]    dvs_r;
  logic [dht_pkg::SIZE_W-1:0]    rem_r;
  logic [dht_pkg::SIZE_W:0]      trial;
  logic [dht_pkg::SIZE_W-1:0]    rem_step;
  logic                          last_step;

  // Bring down the next dividend bit and subtract when it fits.
  always_comb begin
    trial = {rem_r, dvd_r[dht_pkg::KEY_W-1]};
    if (trial >= {1'b0, dvs_r}) begin
      rem_step = dht_pkg::SIZE_W'(trial - {1'b0, dvs_r});
    end else begin
      rem_step = trial[dht_pkg::SIZE_W-1:0];
    end
  end

  assign last_step = (cnt_r == CNT_W'(dht_pkg::KEY_W - 1));

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      busy_nxt = 1'b1;
    end else if (busy_r && last_step) begin
      busy_nxt = 1'b0;
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      cnt_r <= '0;
      dvd_r <= req.dividend;
      dvs_r <= req.divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + CNT_W'(1);
      dvd_r <= {dvd_r[dht_pkg::KEY_W-2:0], 1'b0};
      rem_r <= rem_step;
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;

endmodule

`default_nettype wire

@@ hdl/double_hash_table.sv @@
// Double-hashing table: insert/search over a slot memory with a shared remainder unit.
// A request runs two 31-step remainders (home slot, probe step) on the shared unit, then
// makes 1 .. size+1 probes, each one memory read, until a free slot, a match or the limit.
// A new request is taken only once the previous result has moved into the output register;
// a result still waiting there holds that move off. After reset a clearing pass over all
// TABLE_DEPTH slots empties the slot memory while requests are held off; table_size resets to 256.
`default_nettype none

module double_hash_table #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [dht_pkg::SIZE_W-1:0]  cfg_data,
  dht_req_if.sink                     in_chan,
  dht_rsp_if.source                   out_chan
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int SW = dht_pkg::SIZE_W;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_MOD1  = 3'd2;
  localparam logic [2:0] S_MOD2  = 3'd3;
  localparam logic [2:0] S_PROBE = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]                    state_r, state_nxt;
  logic [AW-1:0]                 clr_r, clr_nxt;
  logic [SW-1:0]                 table_size_r;
  logic [SW-1:0]                 eff_size;
  logic [SW-1:0]                 size_r, size_nxt;
  logic [SW-1:0]                 idx_r, idx_nxt;
  logic [SW-1:0]                 step_r, step_nxt;
  logic [SW-1:0]                 attempt_r, attempt_nxt;
  logic                          kind_r, kind_nxt;
  logic [dht_pkg::KEY_W-1:0]     key_r, key_nxt;
  logic [dht_pkg::REC_W-1:0]     rec_r, rec_nxt;
  logic [dht_pkg::STATUS_W-1:0]  res_status_r, res_status_nxt;
  logic [dht_pkg::REC_W-1:0]     res_rec_r, res_rec_nxt;
  logic [dht_pkg::SLOT_W-1:0]    res_slot_r, res_slot_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [dht_pkg::STATUS_W-1:0]  out_status_r;
  logic [dht_pkg::REC_W-1:0]     out_rec_r;
  logic [dht_pkg::SLOT_W-1:0]    out_slot_r;
  logic                          out_load;

  dht_pkg::mod_req_t             mod_req;
  dht_pkg::mod_rsp_t             mod_rsp;

  dht_pkg::entry_t               mem [TABLE_DEPTH];
  dht_pkg::entry_t               rd_data_r;
  dht_pkg::entry_t               wr_data;
  logic [AW-1:0]                 rd_addr;
  logic [AW-1:0]                 wr_addr;
  logic                          mem_we;

  logic [SW:0]                   diff;
  logic [SW-1:0]                 next_idx;
  logic                          at_limit;
  logic                          key_match;

  dht_mod_unit u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mod_req),
    .rsp   (mod_rsp)
  );

  // Clamp the configured size into 2 .. TABLE_DEPTH.
  always_comb begin
    if (table_size_r < dht_pkg::SIZE_MIN) begin
      eff_size = dht_pkg::SIZE_MIN;
    end else if (int'(table_size_r) > TABLE_DEPTH) begin
      eff_size = SW'(TABLE_DEPTH);
    end else begin
      eff_size = table_size_r;
    end
  end

  // Step back by the probe step, wrap around below zero.
  assign diff     = {1'b0, idx_r} - {1'b0, step_r};
  assign next_idx = diff[SW] ? (diff[SW-1:0] + size_r) : diff[SW-1:0];
  assign at_limit = (attempt_r >= size_r);
  assign key_match = (rd_data_r.key == key_r);

  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    size_nxt       = size_r;
    idx_nxt        = idx_r;
    step_nxt       = step_r;
    attempt_nxt    = attempt_r;
    kind_nxt       = kind_r;
    key_nxt        = key_r;
    rec_nxt        = rec_r;
    res_status_nxt = res_status_r;
    res_rec_nxt    = res_rec_r;
    res_slot_nxt   = res_slot_r;
    out_load       = 1'b0;
    mod_req.start    = 1'b0;
    mod_req.dividend = key_r;
    mod_req.divisor  = size_r;
    mem_we         = 1'b0;
    wr_addr        = AW'(idx_r);
    wr_data.used   = 1'b1;
    wr_data.key    = key_r;
    wr_data.rec    = rec_r;
    rd_addr        = AW'(idx_r);

    case (state_r)
      S_CLEAR: begin
        mem_we  = 1'b1;
        wr_addr = clr_r;
        wr_data = '0;
        if (clr_r == AW'(TABLE_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          clr_nxt = clr_r + AW'(1);
        end
      end
      S_IDLE: begin
        if (in_chan.valid) begin
          kind_nxt         = in_chan.kind;
          key_nxt          = in_chan.key;
          rec_nxt          = in_chan.record_id;
          size_nxt         = eff_size;
          mod_req.start    = 1'b1;
          mod_req.dividend = in_chan.key;
          mod_req.divisor  = eff_size;
          state_nxt        = S_MOD1;
        end
      end
      S_MOD1: begin
        if (mod_rsp.done) begin
          idx_nxt         = mod_rsp.rem;
          mod_req.start   = 1'b1;
          mod_req.divisor = size_r - SW'(1);
          state_nxt       = S_MOD2;
        end
      end
      S_MOD2: begin
        if (mod_rsp.done) begin
          step_nxt    = (size_r - SW'(1)) - mod_rsp.rem;
          attempt_nxt = '0;
          state_nxt   = S_PROBE;
        end
      end
      S_PROBE: begin
        if (!rd_data_r.used) begin
          if (kind_r == dht_pkg::KIND_INSERT) begin
            mem_we         = 1'b1;
            res_status_nxt = dht_pkg::ST_INSERTED;
            res_slot_nxt   = dht_pkg::SLOT_W'(idx_r);
          end else begin
            res_status_nxt = dht_pkg::ST_NOT_FOUND;
            res_slot_nxt   = '0;
          end
          res_rec_nxt = '0;
          state_nxt   = S_DONE;
        end else if (kind_r == dht_pkg::KIND_SEARCH && key_match) begin
          res_status_nxt = dht_pkg::ST_FOUND;
          res_rec_nxt    = rd_data_r.rec;
          res_slot_nxt   = dht_pkg::SLOT_W'(idx_r);
          state_nxt      = S_DONE;
        end else if (at_limit) begin
          res_status_nxt = (kind_r == dht_pkg::KIND_INSERT) ? dht_pkg::ST_FULL
                                                             : dht_pkg::ST_NOT_FOUND;
          res_rec_nxt    = '0;
          res_slot_nxt   = '0;
          state_nxt      = S_DONE;
        end else begin
          // Advance along the probe sequence and read the next slot.
          idx_nxt     = next_idx;
          attempt_nxt = attempt_r + SW'(1);
          rd_addr     = AW'(next_idx);
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_chan.ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = out_load ? 1'b1 : (out_chan.ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_r        <= '0;
      table_size_r <= dht_pkg::SIZE_RESET;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        table_size_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    size_r       <= size_nxt;
    idx_r        <= idx_nxt;
    step_r       <= step_nxt;
    attempt_r    <= attempt_nxt;
    kind_r       <= kind_nxt;
    key_r        <= key_nxt;
    rec_r        <= rec_nxt;
    res_status_r <= res_status_nxt;
    res_rec_r    <= res_rec_nxt;
    res_slot_r   <= res_slot_nxt;
    if (out_load) begin
      out_status_r <= res_status_r;
      out_rec_r    <= res_rec_r;
      out_slot_r   <= res_slot_r;
    end
  end

  // Slot memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign in_chan.ready         = (state_r == S_IDLE);
  assign out_chan.valid        = out_valid_r;
  assign out_chan.status       = out_status_r;
  assign out_chan.found_record = out_rec_r;
  assign out_chan.slot_index   = out_slot_r;

  a_probe_write_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PROBE && mem_we) |-> !rd_data_r.used)
    else $error("probe wrote over an occupied slot");

  a_mod_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    mod_req.start |-> !mod_rsp.busy)
    else $error("remainder unit restarted while busy");

  a_step_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PROBE) |-> (step_r != '0 && step_r < size_r && idx_r < size_r))
    else $error("probe step or slot out of range");

  a_attempt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PROBE) |-> (attempt_r <= size_r))
    else $error("probe count exceeded table size");

endmodule

`default_nettype wire
